// ----- design/swerve_module_kinematics_assert.svh -----
// Assertion macros shared by the kinematics block
`ifndef SWERVE_MODULE_KINEMATICS_ASSERT_SVH
`define SWERVE_MODULE_KINEMATICS_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SMK_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kinematics assertion failed");
`define SMK_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kinematics assertion failed");
`else
`define SMK_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SMK_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- design/smk_pkg.sv -----
// Shared constants, types and helper functions for the kinematics block
`timescale 1ns / 1ps
package smk_pkg;
    localparam int NMOD     = 3;
    localparam int MULW     = 17;
    localparam int PRODW    = 2 * MULW;
    localparam int ZW       = 20;
    localparam int PI_Q12   = 12868;
    localparam int HALF_PI  = 102944;

    typedef enum logic [7:0] {
        CFG_SPEED_LIMITS = 8'd0,
        CFG_ACCEL_LIMITS = 8'd1,
        CFG_MODULE_LIMIT = 8'd2,
        CFG_X_POSITIONS  = 8'd3,
        CFG_Y_POSITIONS  = 8'd4
    } t_cfg_idx;

    // Arctangent of 2^-i in units of 2^-16 rad
    function automatic logic [15:0] atan_q16(input logic [4:0] i);
        case (i)
            5'd0:    return 16'd51472;
            5'd1:    return 16'd30386;
            5'd2:    return 16'd16055;
            5'd3:    return 16'd8150;
            5'd4:    return 16'd4091;
            5'd5:    return 16'd2047;
            5'd6:    return 16'd1024;
            5'd7:    return 16'd512;
            5'd8:    return 16'd256;
            5'd9:    return 16'd128;
            5'd10:   return 16'd64;
            5'd11:   return 16'd32;
            5'd12:   return 16'd16;
            5'd13:   return 16'd8;
            5'd14:   return 16'd4;
            5'd15:   return 16'd2;
            5'd16:   return 16'd1;
            default: return 16'd0;
        endcase
    endfunction

    // Saturate to 16 signed bits
    function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
        if (v > 24'sd32767) begin
            return 16'sh7FFF;
        end else if (v < -24'sd32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction
endpackage

// ----- design/smk_ifs.sv -----
// Handshake channels of the kinematics block
`timescale 1ns / 1ps
interface smk_cmd_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] cmd_vx;
    logic signed [15:0] cmd_vy;
    logic signed [15:0] cmd_wz;
    modport source (output valid, cmd_vx, cmd_vy, cmd_wz, input ready);
    modport sink   (input valid, cmd_vx, cmd_vy, cmd_wz, output ready);
endinterface

interface smk_res_if;
    logic               valid;
    logic               ready;
    logic signed [14:0] heading_0;
    logic signed [14:0] heading_1;
    logic signed [14:0] heading_2;
    logic [15:0]        wheel_speed_0;
    logic [15:0]        wheel_speed_1;
    logic [15:0]        wheel_speed_2;
    logic [15:0]        speed_scale;
    modport source (output valid, heading_0, heading_1, heading_2, wheel_speed_0,
                    wheel_speed_1, wheel_speed_2, speed_scale, input ready);
    modport sink   (input valid, heading_0, heading_1, heading_2, wheel_speed_0,
                    wheel_speed_1, wheel_speed_2, speed_scale, output ready);
endinterface

interface smk_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [47:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/smk_mul.sv -----
// Two-lane bit-serial signed multiplier, one multiplier bit per cycle
`timescale 1ns / 1ps
module smk_mul (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic signed [smk_pkg::MULW-1:0]       i_a0,
    input  logic signed [smk_pkg::MULW-1:0]       i_b0,
    input  logic signed [smk_pkg::MULW-1:0]       i_a1,
    input  logic signed [smk_pkg::MULW-1:0]       i_b1,
    output logic                                  o_done,
    output logic signed [smk_pkg::PRODW-1:0]      o_p0,
    output logic signed [smk_pkg::PRODW-1:0]      o_p1
);
    localparam logic [4:0] LAST = 5'(smk_pkg::MULW - 1);

    logic                              r_busy;
    logic                              r_done;
    logic [4:0]                        r_cnt;
    logic signed [smk_pkg::PRODW-1:0]  r_mc0, r_mc1, r_acc0, r_acc1;
    logic [smk_pkg::MULW-1:0]          r_mp0, r_mp1;

    // Add the shifted multiplicand per set bit; the top bit weighs negative
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_mc0  <= smk_pkg::PRODW'(i_a0);
                r_mc1  <= smk_pkg::PRODW'(i_a1);
                r_mp0  <= i_b0;
                r_mp1  <= i_b1;
                r_acc0 <= '0;
                r_acc1 <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_mp0[0]) begin
                    r_acc0 <= (r_cnt == LAST) ? r_acc0 - r_mc0 : r_acc0 + r_mc0;
                end
                if (r_mp1[0]) begin
                    r_acc1 <= (r_cnt == LAST) ? r_acc1 - r_mc1 : r_acc1 + r_mc1;
                end
                r_mc0 <= r_mc0 <<< 1;
                r_mc1 <= r_mc1 <<< 1;
                r_mp0 <= r_mp0 >> 1;
                r_mp1 <= r_mp1 >> 1;
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_p0   = r_acc0;
    assign o_p1   = r_acc1;
endmodule

// ----- design/smk_cordic.sv -----
// Vectoring CORDIC giving the wheel heading, one iteration per cycle
`timescale 1ns / 1ps
module smk_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [15:0] i_x,
    input  logic signed [15:0] i_y,
    output logic               o_busy,
    output logic signed [14:0] o_heading
);
    localparam int CW = $clog2(CORDIC_STEPS + 1);

    logic                           r_busy;
    logic                           r_zero;
    logic [CW-1:0]                  r_i;
    logic signed [smk_pkg::ZW-1:0]  r_x, r_y, r_z;
    logic signed [smk_pkg::ZW-1:0]  w_xs, w_ys, w_dx, w_dy, w_at, w_zr;

    assign w_xs = smk_pkg::ZW'(i_x);
    assign w_ys = smk_pkg::ZW'(i_y);
    assign w_dx = r_y >>> r_i;
    assign w_dy = r_x >>> r_i;
    assign w_at = smk_pkg::ZW'(smk_pkg::atan_q16(5'(r_i)));
    assign w_zr = (r_z + smk_pkg::ZW'(8)) >>> 4;

    // Pre-rotate the left half-plane, then iterate toward the x axis
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_zero <= (i_x == 16'sd0) && (i_y == 16'sd0);
            r_i    <= '0;
            r_busy <= 1'b1;
            if (i_x < 16'sd0) begin
                if (i_y >= 16'sd0) begin
                    r_x <= w_ys;
                    r_y <= -w_xs;
                    r_z <= smk_pkg::ZW'(smk_pkg::HALF_PI);
                end else begin
                    r_x <= -w_ys;
                    r_y <= w_xs;
                    r_z <= -smk_pkg::ZW'(smk_pkg::HALF_PI);
                end
            end else begin
                r_x <= w_xs;
                r_y <= w_ys;
                r_z <= '0;
            end
        end else if (r_busy) begin
            if (r_y >= 0) begin
                r_x <= r_x + w_dx;
                r_y <= r_y - w_dy;
                r_z <= r_z + w_at;
            end else begin
                r_x <= r_x - w_dx;
                r_y <= r_y + w_dy;
                r_z <= r_z - w_at;
            end
            if (r_i == CW'(CORDIC_STEPS - 1)) begin
                r_busy <= 1'b0;
            end else begin
                r_i <= r_i + CW'(1);
            end
        end
    end

    // Round to Q3.12 and clamp to plus or minus pi
    always_comb begin
        if (r_zero) begin
            o_heading = '0;
        end else if (w_zr > smk_pkg::ZW'(smk_pkg::PI_Q12)) begin
            o_heading = 15'(smk_pkg::PI_Q12);
        end else if (w_zr < -smk_pkg::ZW'(smk_pkg::PI_Q12)) begin
            o_heading = -15'(smk_pkg::PI_Q12);
        end else begin
            o_heading = w_zr[14:0];
        end
    end

    assign o_busy = r_busy;
endmodule

// ----- design/swerve_module_kinematics.sv -----
// Per module: a product pass, forming the wheel vector, a squaring pass,
// 16 square-root steps and one store (CORDIC runs alongside).
// Slew covers each axis in turn; scaling adds 15 divide steps and two product passes.
// One item in flight: a new command is taken only after the last result is registered;
// a result that is not yet taken holds the next one back in S_OUT.
// Reset (synchronous, active low) zeroes the slewed velocity and restores registers.
`timescale 1ns / 1ps
`include "swerve_module_kinematics_assert.svh"
module swerve_module_kinematics #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    smk_cfg_if.sink   i_cfg,
    smk_cmd_if.sink   i_cmd,
    smk_res_if.source o_res
);
    typedef enum logic [3:0] {
        S_IDLE, S_SLEW, S_MPROD, S_FORM, S_MSQ, S_SQRT, S_HEAD,
        S_CHK, S_DIV, S_MSC0, S_MSC1, S_OUT
    } t_state;

    t_state              r_state;
    logic [47:0]         r_spd_lim, r_acc_lim, r_xpos, r_ypos;
    logic [14:0]         r_mod_lim;
    logic signed [15:0]  r_cmd [smk_pkg::NMOD];
    logic signed [15:0]  r_sv  [smk_pkg::NMOD];
    logic [1:0]          r_k;
    logic signed [15:0]  r_wx, r_wy;
    logic [31:0]         r_sq_v, r_sq_r, r_sq_bit;
    logic [4:0]          r_cnt;
    logic [15:0]         r_spd [smk_pkg::NMOD];
    logic signed [14:0]  r_head [smk_pkg::NMOD];
    logic [15:0]         r_max, r_scale, r_rem;
    logic                r_mst, r_cst, r_ov;
    logic signed [14:0]  r_oh [smk_pkg::NMOD];
    logic [15:0]         r_os [smk_pkg::NMOD];
    logic [15:0]         r_osc;

    // Slew datapath for the axis r_k
    logic signed [15:0]  w_cmd, w_cur;
    logic signed [17:0]  w_c, w_lim, w_t;
    logic signed [18:0]  w_d, w_al, w_dc;
    logic signed [23:0]  w_n;

    assign w_cmd = r_cmd[r_k];
    assign w_cur = r_sv[r_k];
    assign w_c   = 18'(w_cmd);
    assign w_lim = {2'b00, r_spd_lim[{r_k, 4'b0000} +: 16]};
    assign w_al  = {3'b000, r_acc_lim[{r_k, 4'b0000} +: 16]};
    assign w_t   = (w_c > w_lim) ? w_lim : ((w_c < -w_lim) ? -w_lim : w_c);
    assign w_d   = 19'(w_t) - 19'(w_cur);
    assign w_dc  = (w_d > w_al) ? w_al : ((w_d < -w_al) ? -w_al : w_d);
    assign w_n   = 24'(w_cur) + 24'(w_dc);

    // Wheel vector from the two products
    logic                                 w_mdone;
    logic signed [smk_pkg::PRODW-1:0]     w_p0, w_p1;
    logic signed [23:0]                   w_fx, w_fy;
    logic signed [15:0]                   w_px, w_py;

    assign w_px = r_xpos[{r_k, 4'b0000} +: 16];
    assign w_py = r_ypos[{r_k, 4'b0000} +: 16];
    assign w_fx = 24'(r_sv[0]) - 24'(w_p0 >>> 11);
    assign w_fy = 24'(r_sv[1]) + 24'(w_p1 >>> 11);

    // Multiplier operands by phase
    logic signed [smk_pkg::MULW-1:0] w_a0, w_b0, w_a1, w_b1, w_ax, w_ay;

    assign w_ax = (r_wx < 16'sd0) ? -smk_pkg::MULW'(r_wx) : smk_pkg::MULW'(r_wx);
    assign w_ay = (r_wy < 16'sd0) ? -smk_pkg::MULW'(r_wy) : smk_pkg::MULW'(r_wy);

    always_comb begin
        w_a0 = '0;
        w_b0 = '0;
        w_a1 = '0;
        w_b1 = '0;
        case (r_state)
            S_MPROD: begin
                w_a0 = smk_pkg::MULW'(r_sv[2]);
                w_b0 = smk_pkg::MULW'(w_py);
                w_a1 = smk_pkg::MULW'(r_sv[2]);
                w_b1 = smk_pkg::MULW'(w_px);
            end
            S_MSQ: begin
                w_a0 = w_ax;
                w_b0 = w_ax;
                w_a1 = w_ay;
                w_b1 = w_ay;
            end
            S_MSC0: begin
                w_a0 = {1'b0, r_spd[0]};
                w_b0 = {2'b00, r_scale[14:0]};
                w_a1 = {1'b0, r_spd[1]};
                w_b1 = {2'b00, r_scale[14:0]};
            end
            S_MSC1: begin
                w_a0 = {1'b0, r_spd[2]};
                w_b0 = {2'b00, r_scale[14:0]};
            end
            default: begin
                w_a0 = '0;
            end
        endcase
    end

    smk_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mst),
        .i_a0    (w_a0),
        .i_b0    (w_b0),
        .i_a1    (w_a1),
        .i_b1    (w_b1),
        .o_done  (w_mdone),
        .o_p0    (w_p0),
        .o_p1    (w_p1)
    );

    logic               w_cbusy;
    logic signed [14:0] w_chead;

    smk_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_cst),
        .i_x       (r_wx),
        .i_y       (r_wy),
        .o_busy    (w_cbusy),
        .o_heading (w_chead)
    );

    // Square-root and divide digit steps
    logic [31:0] w_sq_t;
    logic [16:0] w_rs;

    assign w_sq_t = r_sq_r + r_sq_bit;
    assign w_rs   = {r_rem, 1'b0};

    // Configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spd_lim <= '0;
            r_acc_lim <= '0;
            r_mod_lim <= 15'h7FFF;
            r_xpos    <= '0;
            r_ypos    <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                smk_pkg::CFG_SPEED_LIMITS: r_spd_lim <= i_cfg.data;
                smk_pkg::CFG_ACCEL_LIMITS: r_acc_lim <= i_cfg.data;
                smk_pkg::CFG_MODULE_LIMIT: r_mod_lim <= i_cfg.data[14:0];
                smk_pkg::CFG_X_POSITIONS:  r_xpos    <= i_cfg.data;
                smk_pkg::CFG_Y_POSITIONS:  r_ypos    <= i_cfg.data;
                default:                   r_mod_lim <= r_mod_lim;
            endcase
        end
    end

    assign i_cmd.ready = (r_state == S_IDLE);

    // Sequencer with its datapath registers and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_mst   <= 1'b0;
            r_cst   <= 1'b0;
            for (int j = 0; j < smk_pkg::NMOD; j++) begin
                r_sv[j] <= '0;
            end
        end else begin
            r_mst <= 1'b0;
            r_cst <= 1'b0;
            // Drop a taken result; S_OUT refills the register itself
            if (r_ov && o_res.ready && (r_state != S_OUT)) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        r_cmd[0] <= i_cmd.cmd_vx;
                        r_cmd[1] <= i_cmd.cmd_vy;
                        r_cmd[2] <= i_cmd.cmd_wz;
                        r_k      <= '0;
                        r_max    <= '0;
                        r_state  <= S_SLEW;
                    end
                end
                S_SLEW: begin
                    r_sv[r_k] <= smk_pkg::sat16(w_n);
                    if (r_k == 2'd2) begin
                        r_k     <= '0;
                        r_mst   <= 1'b1;
                        r_state <= S_MPROD;
                    end else begin
                        r_k <= r_k + 2'd1;
                    end
                end
                S_MPROD: begin
                    if (w_mdone) begin
                        r_state <= S_FORM;
                    end
                end
                S_FORM: begin
                    r_wx    <= smk_pkg::sat16(w_fx);
                    r_wy    <= smk_pkg::sat16(w_fy);
                    r_mst   <= 1'b1;
                    r_cst   <= 1'b1;
                    r_state <= S_MSQ;
                end
                S_MSQ: begin
                    if (w_mdone) begin
                        r_sq_v   <= w_p0[31:0] + w_p1[31:0];
                        r_sq_r   <= '0;
                        r_sq_bit <= 32'h4000_0000;
                        r_cnt    <= '0;
                        r_state  <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (r_sq_v >= w_sq_t) begin
                        r_sq_v <= r_sq_v - w_sq_t;
                        r_sq_r <= (r_sq_r >> 1) + r_sq_bit;
                    end else begin
                        r_sq_r <= r_sq_r >> 1;
                    end
                    r_sq_bit <= r_sq_bit >> 2;
                    r_cnt    <= r_cnt + 5'd1;
                    if (r_cnt == 5'd15) begin
                        r_state <= S_HEAD;
                    end
                end
                S_HEAD: begin
                    if (!w_cbusy) begin
                        r_spd[r_k]  <= r_sq_r[15:0];
                        r_head[r_k] <= w_chead;
                        if (r_sq_r[15:0] > r_max) begin
                            r_max <= r_sq_r[15:0];
                        end
                        if (r_k == 2'd2) begin
                            r_state <= S_CHK;
                        end else begin
                            r_k     <= r_k + 2'd1;
                            r_mst   <= 1'b1;
                            r_state <= S_MPROD;
                        end
                    end
                end
                S_CHK: begin
                    if (r_max > {1'b0, r_mod_lim}) begin
                        r_rem   <= {1'b0, r_mod_lim};
                        r_scale <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_scale <= 16'h8000;
                        r_state <= S_OUT;
                    end
                end
                S_DIV: begin
                    if (w_rs >= {1'b0, r_max}) begin
                        r_rem   <= 16'(w_rs - {1'b0, r_max});
                        r_scale <= {r_scale[14:0], 1'b1};
                    end else begin
                        r_rem   <= w_rs[15:0];
                        r_scale <= {r_scale[14:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd14) begin
                        r_mst   <= 1'b1;
                        r_state <= S_MSC0;
                    end
                end
                S_MSC0: begin
                    if (w_mdone) begin
                        r_spd[0] <= w_p0[30:15];
                        r_spd[1] <= w_p1[30:15];
                        r_mst    <= 1'b1;
                        r_state  <= S_MSC1;
                    end
                end
                S_MSC1: begin
                    if (w_mdone) begin
                        r_spd[2] <= w_p0[30:15];
                        r_state  <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_ov || o_res.ready) begin
                        for (int j = 0; j < smk_pkg::NMOD; j++) begin
                            r_oh[j] <= r_head[j];
                            r_os[j] <= r_spd[j];
                        end
                        r_osc   <= r_scale;
                        r_ov    <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid         = r_ov;
    assign o_res.heading_0     = r_oh[0];
    assign o_res.heading_1     = r_oh[1];
    assign o_res.heading_2     = r_oh[2];
    assign o_res.wheel_speed_0 = r_os[0];
    assign o_res.wheel_speed_1 = r_os[1];
    assign o_res.wheel_speed_2 = r_os[2];
    assign o_res.speed_scale   = r_osc;

    // Conditions checked by the assertions below
    logic w_hd_ok, w_mul_ph;

    assign w_hd_ok  = (r_oh[0] <= 15'sd12868) && (r_oh[0] >= -15'sd12868);
    assign w_mul_ph = (r_state == S_MPROD) || (r_state == S_MSQ) ||
                      (r_state == S_MSC0) || (r_state == S_MSC1);

    `SMK_ASSERT_NXT(a_accept_slew, i_clk, i_rst_n, i_cmd.valid && i_cmd.ready, r_state == S_SLEW)
    `SMK_ASSERT_IMP(a_scale_max, i_clk, i_rst_n, r_ov, r_osc <= 16'h8000)
    `SMK_ASSERT_IMP(a_hdg_range, i_clk, i_rst_n, r_ov, w_hd_ok)
    `SMK_ASSERT_IMP(a_mul_phase, i_clk, i_rst_n, r_mst, w_mul_ph)
endmodule
